// ----- hw/rtl/qrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Types, widths and helpers for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int CoefW    = 16;                 // Q8.8 coefficient
    localparam int RootW    = 32;                 // Q16.16 root
    localparam int ProdW    = 2 * CoefW;          // b*b, a*c
    localparam int DiscW    = ProdW + 3;          // b*b - 4ac, exact
    localparam int RadW     = 50;                 // radicand D << 16 plus headroom
    localparam int SqSteps  = 25;                 // result bits of the square root
    localparam int NumW     = 27;                 // -b*256 +/- s
    localparam int DvdW     = 34;                 // |num| * 128
    localparam int DivSteps = DvdW;               // one quotient bit per stage
    localparam int RemW     = CoefW + 1;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_TWO   = 2'd2,
        KIND_DEGEN = 2'd3
    } root_kind_t;

    // Side data riding beside the square root stages
    typedef struct packed {
        logic                    valid;
        logic signed [CoefW-1:0] a;
        logic signed [CoefW-1:0] b;
        root_kind_t              kind;
    } sq_side_t;

    // Side data riding beside the divider stages
    typedef struct packed {
        logic             valid;
        root_kind_t       kind;
        logic [CoefW-1:0] dsr;      // |a|
        logic             neg_p;
        logic             neg_m;
    } dv_side_t;

    typedef struct packed {
        logic             sat;
        logic [RootW-1:0] value;
    } clip_t;

    // Sign-magnitude quotient to saturated two's complement root
    function automatic clip_t clip_root(input logic [DvdW-1:0] q, input logic neg);
        clip_t res;
        res.sat   = 1'b0;
        res.value = q[RootW-1:0];
        if (neg) begin
            if (q > DvdW'(64'h8000_0000)) begin
                res.sat   = 1'b1;
                res.value = {1'b1, {(RootW-1){1'b0}}};
            end else begin
                res.value = RootW'(-q[RootW-1:0]);
            end
        end else if (q > DvdW'(64'h7FFF_FFFF)) begin
            res.sat   = 1'b1;
            res.value = {1'b0, {(RootW-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/quadratic_root_solver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Real roots of a*x^2 + b*x + c from Q8.8 coefficients, Q16.16 results.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                 tuser (low bit up)
// s_       in   coef_a[15:0] coef_b coef_c (48b)   -
// m_       out  root_plus[31:0] root_minus (64b)   root_kind[1:0] saturated
//
// One transfer in per cycle while m_ does not stall. The path from input
// transfer to result: 2 stages for the exact discriminant, 25 square root
// stages (one result bit each), 1 numerator stage, 34 divider stages (one
// quotient bit each, both roots in parallel lanes) and the output register.
// A stall on m_ freezes the whole pipe in place; s_tready drops only while
// a result sits unaccepted in the output register. Reset clears valid bits.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit
    import qrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // coef_a[15:0], coef_b[31:16], coef_c[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // root_plus[31:0], root_minus[63:32]
    output logic [2:0]  m_tuser     // root_kind[1:0], saturated[2]
);

    // Global advance: pipe moves whenever the output slot is free or drains
    logic en;
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    // ---------------- stage 1: products ----------------
    logic signed [CoefW-1:0] in_a, in_b, in_c;
    assign in_a = s_tdata[15:0];
    assign in_b = s_tdata[31:16];
    assign in_c = s_tdata[47:32];

    sq_side_t                p1_side_reg;
    logic signed [ProdW-1:0] p1_bb_reg, p1_ac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_side_reg <= '0;
        end else if (en) begin
            p1_side_reg <= '{valid: s_tvalid, a: in_a, b: in_b, kind: KIND_NONE};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_bb_reg <= in_b * in_b;
            p1_ac_reg <= in_a * in_c;
        end
    end

    // ---------------- stage 2: discriminant, classify ----------------
    logic signed [DiscW-1:0] disc;
    root_kind_t              kind_next;
    assign disc = DiscW'(p1_bb_reg) - (DiscW'(p1_ac_reg) <<< 2);

    always_comb begin
        if (p1_side_reg.a == '0)   kind_next = KIND_DEGEN;
        else if (disc[DiscW-1])    kind_next = KIND_NONE;
        else if (disc == '0)       kind_next = KIND_ONE;
        else                       kind_next = KIND_TWO;
    end

    // Square root pipe: index 0 is loaded here, index k+1 after step k
    sq_side_t       sq_side_reg [0:SqSteps];
    logic [RadW-1:0] sq_v_reg   [0:SqSteps];
    logic [RadW-1:0] sq_r_reg   [0:SqSteps];
    logic [RadW-1:0] sq_v_next  [0:SqSteps-1];
    logic [RadW-1:0] sq_r_next  [0:SqSteps-1];

    // Digit-by-digit floor sqrt; bit weight of step k is 4^(SqSteps-1-k)
    always_comb begin
        for (int k = 0; k < SqSteps; k++) begin
            logic [RadW-1:0] bitw;
            logic [RadW-1:0] trial;
            bitw  = RadW'(1) << (2 * (SqSteps - 1 - k));
            trial = sq_r_reg[k] + bitw;
            if (sq_v_reg[k] >= trial) begin
                sq_v_next[k] = sq_v_reg[k] - trial;
                sq_r_next[k] = (sq_r_reg[k] >> 1) + bitw;
            end else begin
                sq_v_next[k] = sq_v_reg[k];
                sq_r_next[k] = sq_r_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= SqSteps; k++) sq_side_reg[k] <= '0;
        end else if (en) begin
            sq_side_reg[0] <= '{valid: p1_side_reg.valid, a: p1_side_reg.a,
                                b: p1_side_reg.b, kind: kind_next};
            for (int k = 0; k < SqSteps; k++) sq_side_reg[k+1] <= sq_side_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Only a positive discriminant gets a nonzero radicand
            sq_v_reg[0] <= (kind_next == KIND_TWO) ? {1'b0, disc[32:0], 16'b0} : '0;
            sq_r_reg[0] <= '0;
            for (int k = 0; k < SqSteps; k++) begin
                sq_v_reg[k+1] <= sq_v_next[k];
                sq_r_reg[k+1] <= sq_r_next[k];
            end
        end
    end

    // ---------------- numerator stage ----------------
    sq_side_t                sq_out;
    logic [SqSteps-1:0]      sroot;
    logic signed [NumW-1:0]  bneg, num_p, num_m;
    logic [NumW-1:0]         mag_p, mag_m;
    logic [CoefW-1:0]        a_mag;

    assign sq_out = sq_side_reg[SqSteps];
    assign sroot  = sq_r_reg[SqSteps][SqSteps-1:0];
    assign bneg   = -(NumW'(sq_out.b) <<< 8);
    assign num_p  = bneg + $signed({2'b0, sroot});
    assign num_m  = bneg - $signed({2'b0, sroot});
    assign mag_p  = num_p[NumW-1] ? NumW'(-num_p) : NumW'(num_p);
    assign mag_m  = num_m[NumW-1] ? NumW'(-num_m) : NumW'(num_m);
    assign a_mag  = sq_out.a[CoefW-1] ? CoefW'(-sq_out.a) : CoefW'(sq_out.a);

    // Divider pipe: two lanes, lane 0 = plus root, lane 1 = minus root
    dv_side_t         dv_side_reg [0:DivSteps];
    logic [RemW-1:0]  dv_rem_reg  [0:DivSteps][0:1];
    logic [DvdW-1:0]  dv_q_reg    [0:DivSteps][0:1];
    logic [RemW-1:0]  dv_rem_next [0:DivSteps-1][0:1];
    logic [DvdW-1:0]  dv_q_next   [0:DivSteps-1][0:1];

    // Restoring division: dividend bits shift out the top, quotient in at bottom
    always_comb begin
        for (int k = 0; k < DivSteps; k++) begin
            for (int l = 0; l < 2; l++) begin
                logic [RemW-1:0] cat;
                cat = {dv_rem_reg[k][l][RemW-2:0], dv_q_reg[k][l][DvdW-1]};
                if (cat >= {1'b0, dv_side_reg[k].dsr}) begin
                    dv_rem_next[k][l] = cat - {1'b0, dv_side_reg[k].dsr};
                    dv_q_next[k][l]   = {dv_q_reg[k][l][DvdW-2:0], 1'b1};
                end else begin
                    dv_rem_next[k][l] = cat;
                    dv_q_next[k][l]   = {dv_q_reg[k][l][DvdW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DivSteps; k++) dv_side_reg[k] <= '0;
        end else if (en) begin
            dv_side_reg[0] <= '{valid: sq_out.valid, kind: sq_out.kind, dsr: a_mag,
                                neg_p: num_p[NumW-1] ^ sq_out.a[CoefW-1],
                                neg_m: num_m[NumW-1] ^ sq_out.a[CoefW-1]};
            for (int k = 0; k < DivSteps; k++) dv_side_reg[k+1] <= dv_side_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0][0] <= '0;
            dv_rem_reg[0][1] <= '0;
            dv_q_reg[0][0]   <= {mag_p, 7'b0};
            dv_q_reg[0][1]   <= {mag_m, 7'b0};
            for (int k = 0; k < DivSteps; k++) begin
                for (int l = 0; l < 2; l++) begin
                    dv_rem_reg[k+1][l] <= dv_rem_next[k][l];
                    dv_q_reg[k+1][l]   <= dv_q_next[k][l];
                end
            end
        end
    end

    // ---------------- output register ----------------
    dv_side_t   dv_out;
    clip_t      clip_p, clip_m;
    logic       has_root;

    assign dv_out   = dv_side_reg[DivSteps];
    assign clip_p   = clip_root(dv_q_reg[DivSteps][0], dv_out.neg_p);
    assign clip_m   = clip_root(dv_q_reg[DivSteps][1], dv_out.neg_m);
    assign has_root = (dv_out.kind == KIND_ONE) || (dv_out.kind == KIND_TWO);

    logic             out_valid_reg;
    root_kind_t       out_kind_reg;
    logic [RootW-1:0] out_plus_reg, out_minus_reg;
    logic             out_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_kind_reg  <= dv_out.kind;
            out_plus_reg  <= has_root ? clip_p.value : '0;
            out_minus_reg <= has_root ? clip_m.value : '0;
            out_sat_reg   <= has_root && (clip_p.sat || clip_m.sat);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_minus_reg, out_plus_reg};
    assign m_tuser  = {out_sat_reg, out_kind_reg};

`ifndef NO_ASSERTIONS
    // No roots or degenerate input carries all-zero payload
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_kind_reg == KIND_NONE || out_kind_reg == KIND_DEGEN)
        |-> (out_plus_reg == '0) && (out_minus_reg == '0) && !out_sat_reg)
        else $error("nonzero payload without real roots");

    // A double root reports the same value in both fields
    a_one_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_kind_reg == KIND_ONE |-> out_plus_reg == out_minus_reg)
        else $error("double root differs between lanes");

    // A valid item at the divider tail reaches the output on the next advance
    a_tail_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        en && dv_out.valid |=> m_tvalid)
        else $error("item lost at output register");

    // Pipe holds still while a result waits
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(dv_side_reg[DivSteps]) && $stable(sq_side_reg[SqSteps]))
        else $error("pipe moved during stall");
`endif

endmodule
